>>> rtl/core/psg_pkg.sv
// ----------------------------------------------------------------------------
// Performance-state governor package
// Field widths and configuration register indexes shared by the request and response interfaces and the core.
// ----------------------------------------------------------------------------
`default_nettype none

package psg_pkg;

    // Request and response field widths.
    localparam int GAP_W  = 11;
    localparam int CNT_W  = 6;
    localparam int ST_W   = 5;

    // Configuration port widths.
    localparam int KEEP_W     = 7;
    localparam int SWITCH_W   = 10;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_STATES  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_STATES = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEEP_THR    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SWITCH_THR  = 2'd3;

endpackage

`default_nettype wire

>>> rtl/core/psg_req_if.sv
// ----------------------------------------------------------------------------
// Performance-state governor request interface
// Valid/ready channel carrying one governor request per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface psg_req_if;
    import psg_pkg::*;

    logic                    valid;
    logic                    ready;
    logic                    profile_valid;
    logic                    fresh_app;
    logic signed [GAP_W-1:0] goal_gap;
    logic                    on_high_cluster;
    logic [CNT_W-1:0]        state_count;
    logic [ST_W-1:0]         current_state;

    modport source (
        output valid, profile_valid, fresh_app, goal_gap,
        output on_high_cluster, state_count, current_state,
        input  ready
    );

    modport sink (
        input  valid, profile_valid, fresh_app, goal_gap,
        input  on_high_cluster, state_count, current_state,
        output ready
    );

endinterface

`default_nettype wire

>>> rtl/core/psg_rsp_if.sv
// ----------------------------------------------------------------------------
// Performance-state governor response interface
// Valid/ready channel carrying one governor decision per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface psg_rsp_if;
    import psg_pkg::*;

    logic            valid;
    logic            ready;
    logic            action;
    logic            target_high_cluster;
    logic [ST_W-1:0] next_state;

    modport source (
        output valid, action, target_high_cluster, next_state,
        input  ready
    );

    modport sink (
        input  valid, action, target_high_cluster, next_state,
        output ready
    );

endinterface

`default_nettype wire

>>> rtl/core/perf_state_governor_step_unit.sv
// ----------------------------------------------------------------------------
// Performance-state governor step unit
// Decides an application's next cluster and performance state per request.
// ----------------------------------------------------------------------------
// The unit takes one request transaction per clock when the output side is not
// stalling, and returns one decision per request, in order. The pipeline depth
// is set by the exact boost-ratio division: after three stages of product and
// sum formation and one stage of sign handling and range check, a restoring
// divider spends one pipeline stage on each of its six quotient bits, and a
// final stage clamps the state and registers the result.
// Every stage carries its own valid bit and only holds while its successor is
// full and stalled, so empty slots are filled even while a finished decision
// waits at the output. Configuration registers are sampled as requests enter.
// ----------------------------------------------------------------------------
`default_nettype none

module perf_state_governor_step_unit #(
    parameter int MAX_PSTATES = 32
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [psg_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [psg_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    psg_req_if.sink                              i_req,
    psg_rsp_if.source                            o_rsp
);
    import psg_pkg::*;

    localparam int CAP_I = (MAX_PSTATES - 1 > (2**ST_W) - 1) ?
                           (2**ST_W) - 1 : MAX_PSTATES - 1;
    localparam logic [ST_W-1:0] STATE_CAP = ST_W'(CAP_I);

    localparam int QW     = 6;              // quotient bits kept by the divider
    localparam int PROD_W = 18;             // demand times state count
    localparam int PGAP_W = 7;
    localparam int P100_W = 14;
    localparam int SUM_W  = 19;
    localparam int DEN_W  = 13;
    localparam int NUM_W  = 24;             // numerator magnitude
    localparam int NSTG   = 4 + QW + 1;

    typedef struct packed {
        logic             bypass;
        logic             action;
        logic             tgt_high;
        logic [ST_W-1:0]  state;
        logic [CNT_W-1:0] count;
    } t_meta;

    // Configuration registers.
    logic [CNT_W-1:0]    r_low_states;
    logic [CNT_W-1:0]    r_high_states;
    logic [KEEP_W-1:0]   r_keep_thr;
    logic [SWITCH_W-1:0] r_switch_thr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low_states  <= CNT_W'(8);
            r_high_states <= CNT_W'(8);
            r_keep_thr    <= KEEP_W'(5);
            r_switch_thr  <= SWITCH_W'(50);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_LOW_STATES:  r_low_states  <= i_cfg_wdata[CNT_W-1:0];
                CFG_HIGH_STATES: r_high_states <= i_cfg_wdata[CNT_W-1:0];
                CFG_KEEP_THR:    r_keep_thr    <= i_cfg_wdata[KEEP_W-1:0];
                CFG_SWITCH_THR:  r_switch_thr  <= i_cfg_wdata[SWITCH_W-1:0];
                default: ;
            endcase
        end
    end

    function automatic logic [ST_W-1:0] half_cap(input logic [CNT_W-1:0] cnt);
        logic [ST_W-1:0] h;
        h = cnt[CNT_W-1:1];
        return (h > STATE_CAP) ? STATE_CAP : h;
    endfunction

    // Pipeline flow control: a stage advances when it is empty or its
    // successor advances.
    logic [NSTG-1:0] r_vld;
    logic [NSTG:0]   w_adv;

    always_comb begin
        w_adv[NSTG] = o_rsp.ready;
        for (int k = NSTG - 1; k >= 0; k--) begin
            w_adv[k] = !r_vld[k] || w_adv[k+1];
        end
    end

    assign i_req.ready = w_adv[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_adv[0]) begin
                r_vld[0] <= i_req.valid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (w_adv[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: decision class, demand times count, performance gap.
    // ------------------------------------------------------------------
    logic signed [GAP_W:0]    w0_gap;
    logic signed [GAP_W:0]    w0_dem;
    logic signed [GAP_W:0]    w0_sw;
    logic [GAP_W-1:0]         w0_mag;
    logic [CNT_W-1:0]         w0_c;
    logic signed [PROD_W-1:0] w0_prod;
    logic signed [PGAP_W-1:0] w0_pgap;
    t_meta                    w0_meta;

    always_comb begin
        w0_gap  = {i_req.goal_gap[GAP_W-1], i_req.goal_gap};
        w0_dem  = -w0_gap;
        w0_sw   = $signed({{(GAP_W + 1 - SWITCH_W){1'b0}}, r_switch_thr});
        w0_mag  = w0_gap[GAP_W] ? w0_dem[GAP_W-1:0] : w0_gap[GAP_W-1:0];
        w0_c    = {1'b0, i_req.current_state} + CNT_W'(1);
        w0_prod = $signed({{(PROD_W - GAP_W - 1){w0_dem[GAP_W]}}, w0_dem})
                * $signed({{(PROD_W - CNT_W){1'b0}}, i_req.state_count});
        w0_pgap = $signed({1'b0, i_req.state_count}) - $signed({1'b0, w0_c});

        w0_meta.bypass   = 1'b1;
        w0_meta.action   = 1'b1;
        w0_meta.tgt_high = 1'b0;
        w0_meta.state    = '0;
        w0_meta.count    = i_req.state_count;

        if (!i_req.profile_valid) begin
            w0_meta.action = i_req.fresh_app;
            w0_meta.state  = i_req.fresh_app ? half_cap(r_low_states) : '0;
        end else if (w0_mag < {{(GAP_W - KEEP_W){1'b0}}, r_keep_thr}) begin
            w0_meta.action = 1'b0;
        end else if (i_req.fresh_app) begin
            w0_meta.state = half_cap(r_low_states);
        end else if (w0_dem >= w0_sw && !i_req.on_high_cluster) begin
            w0_meta.tgt_high = 1'b1;
            w0_meta.state    = half_cap(r_high_states);
        end else if (w0_dem <= -w0_sw && i_req.on_high_cluster) begin
            w0_meta.state = half_cap(r_low_states);
        end else begin
            // Stay on the current cluster and scale the state.
            w0_meta.bypass   = 1'b0;
            w0_meta.tgt_high = i_req.on_high_cluster;
        end
    end

    t_meta                    r_s1_meta;
    logic [CNT_W-1:0]         r_s1_c;
    logic                     r_s1_dpos;
    logic signed [PGAP_W-1:0] r_s1_pgap;
    logic signed [PROD_W-1:0] r_s1_prod;

    always_ff @(posedge i_clk) begin
        if (w_adv[0]) begin
            r_s1_meta <= w0_meta;
            r_s1_c    <= w0_c;
            r_s1_dpos <= !w0_dem[GAP_W] && (w0_dem != '0);
            r_s1_pgap <= w0_pgap;
            r_s1_prod <= w0_prod;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: numerator sum and divisor.
    // ------------------------------------------------------------------
    logic signed [P100_W-1:0] w1_p100;
    logic [P100_W-1:0]        w1_p100n;
    logic signed [SUM_W-1:0]  w1_sum;
    logic [DEN_W-1:0]         w1_dmag;
    logic                     w1_dneg;
    logic                     w1_mulc;

    always_comb begin
        w1_p100  = $signed({{(P100_W - PGAP_W){r_s1_pgap[PGAP_W-1]}}, r_s1_pgap})
                 * $signed(P100_W'(100));
        w1_p100n = -w1_p100;
        if (r_s1_dpos && r_s1_pgap != '0) begin
            w1_sum  = $signed({{(SUM_W - P100_W){w1_p100[P100_W-1]}}, w1_p100})
                    + $signed({{(SUM_W - PROD_W){r_s1_prod[PROD_W-1]}}, r_s1_prod});
            w1_dneg = w1_p100[P100_W-1];
            w1_dmag = w1_dneg ? w1_p100n[DEN_W-1:0] : w1_p100[DEN_W-1:0];
            w1_mulc = 1'b1;
        end else if (r_s1_dpos) begin
            // Already at the top state: the ratio leaves it where it is.
            w1_sum  = $signed({{(SUM_W - CNT_W){1'b0}}, r_s1_c});
            w1_dneg = 1'b0;
            w1_dmag = DEN_W'(1);
            w1_mulc = 1'b0;
        end else begin
            w1_sum  = $signed(SUM_W'(r_s1_c) * SUM_W'(100))
                    + $signed({{(SUM_W - PROD_W){r_s1_prod[PROD_W-1]}}, r_s1_prod});
            w1_dneg = 1'b0;
            w1_dmag = DEN_W'(100);
            w1_mulc = 1'b0;
        end
    end

    t_meta                   r_s2_meta;
    logic [CNT_W-1:0]        r_s2_c;
    logic signed [SUM_W-1:0] r_s2_sum;
    logic [DEN_W-1:0]        r_s2_dmag;
    logic                    r_s2_dneg;
    logic                    r_s2_mulc;

    always_ff @(posedge i_clk) begin
        if (w_adv[1]) begin
            r_s2_meta <= r_s1_meta;
            r_s2_c    <= r_s1_c;
            r_s2_sum  <= w1_sum;
            r_s2_dmag <= w1_dmag;
            r_s2_dneg <= w1_dneg;
            r_s2_mulc <= w1_mulc;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: scale the sum by the current state.
    // ------------------------------------------------------------------
    logic signed [NUM_W:0] w2_sumx;
    logic signed [NUM_W:0] w2_num;

    always_comb begin
        w2_sumx = $signed({{(NUM_W + 1 - SUM_W){r_s2_sum[SUM_W-1]}}, r_s2_sum});
        w2_num  = r_s2_mulc ?
                  w2_sumx * $signed({{(NUM_W + 1 - CNT_W){1'b0}}, r_s2_c}) : w2_sumx;
    end

    t_meta                 r_s3_meta;
    logic signed [NUM_W:0] r_s3_num;
    logic [DEN_W-1:0]      r_s3_dmag;
    logic                  r_s3_dneg;

    always_ff @(posedge i_clk) begin
        if (w_adv[2]) begin
            r_s3_meta <= r_s2_meta;
            r_s3_num  <= w2_num;
            r_s3_dmag <= r_s2_dmag;
            r_s3_dneg <= r_s2_dneg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: magnitudes, quotient sign, quotient range check.
    // ------------------------------------------------------------------
    logic [NUM_W:0]   w3_neg;
    logic [NUM_W-1:0] w3_mag;
    logic             w3_ovf;

    always_comb begin
        w3_neg = -r_s3_num;
        w3_mag = r_s3_num[NUM_W] ? w3_neg[NUM_W-1:0] : r_s3_num[NUM_W-1:0];
        w3_ovf = w3_mag >= NUM_W'({r_s3_dmag, {QW{1'b0}}});
    end

    // Divider stage 0 holds the prepared operands; stage j resolves one bit.
    t_meta            r_dv_meta [0:QW];
    logic [NUM_W-1:0] r_dv_rem  [0:QW];
    logic [QW-1:0]    r_dv_q    [0:QW];
    logic [DEN_W-1:0] r_dv_dmag [0:QW];
    logic             r_dv_pos  [0:QW];
    logic             r_dv_ovf  [0:QW];

    always_ff @(posedge i_clk) begin
        if (w_adv[3]) begin
            r_dv_meta[0] <= r_s3_meta;
            r_dv_rem[0]  <= w3_mag;
            r_dv_q[0]    <= '0;
            r_dv_dmag[0] <= r_s3_dmag;
            r_dv_pos[0]  <= r_s3_num[NUM_W] == r_s3_dneg;
            r_dv_ovf[0]  <= w3_ovf;
        end
    end

    for (genvar j = 1; j <= QW; j++) begin : g_div
        logic [NUM_W-1:0] w_sub;
        logic             w_ge;

        assign w_sub = NUM_W'(r_dv_dmag[j-1]) << (QW - j);
        assign w_ge  = r_dv_rem[j-1] >= w_sub;

        always_ff @(posedge i_clk) begin
            if (w_adv[3+j]) begin
                r_dv_meta[j] <= r_dv_meta[j-1];
                r_dv_rem[j]  <= w_ge ? r_dv_rem[j-1] - w_sub : r_dv_rem[j-1];
                r_dv_q[j]    <= r_dv_q[j-1] | (QW'(w_ge) << (QW - j));
                r_dv_dmag[j] <= r_dv_dmag[j-1];
                r_dv_pos[j]  <= r_dv_pos[j-1];
                r_dv_ovf[j]  <= r_dv_ovf[j-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Output stage: clamp the state and register the decision.
    // ------------------------------------------------------------------
    t_meta            w9_meta;
    logic [QW-1:0]    w9_q;
    logic [QW-1:0]    w9_m;
    logic [CNT_W-1:0] w9_hi;
    logic [CNT_W-1:0] w9_lim;
    logic [ST_W-1:0]  w9_state;

    always_comb begin
        w9_meta = r_dv_meta[QW];
        // A quotient beyond the divider's range saturates, so a positive one clamps to the limit.
        w9_q    = r_dv_ovf[QW] ? '1 : r_dv_q[QW];
        w9_m    = w9_q - QW'(1);
        w9_hi   = w9_meta.count - CNT_W'(1);
        w9_lim  = (w9_hi > CNT_W'(STATE_CAP)) ? CNT_W'(STATE_CAP) : w9_hi;
        if (w9_meta.bypass) begin
            w9_state = w9_meta.state;
        end else if (!r_dv_pos[QW] || w9_q == '0 || w9_meta.count == '0) begin
            w9_state = '0;
        end else if (CNT_W'(w9_m) > w9_lim) begin
            w9_state = w9_lim[ST_W-1:0];
        end else begin
            w9_state = w9_m[ST_W-1:0];
        end
    end

    logic            r_o_action;
    logic            r_o_tgt_high;
    logic [ST_W-1:0] r_o_state;

    always_ff @(posedge i_clk) begin
        if (w_adv[NSTG-1]) begin
            r_o_action   <= w9_meta.action;
            r_o_tgt_high <= w9_meta.action ? w9_meta.tgt_high : 1'b0;
            r_o_state    <= w9_meta.action ? w9_state : '0;
        end
    end

    assign o_rsp.valid               = r_vld[NSTG-1];
    assign o_rsp.action              = r_o_action;
    assign o_rsp.target_high_cluster = r_o_tgt_high;
    assign o_rsp.next_state          = r_o_state;

endmodule

`default_nettype wire
